// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, off while reset is held
`define SSDF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property, also during reset
`define SSDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ssdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdf_pkg
// types and constants of the sphere signed distance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssdf_pkg;

    localparam int PT_W   = 43;
    localparam int MAG_W  = 43;
    localparam int SQ_W   = 88;
    localparam int ROOT_W = 44;
    localparam int REM_W  = 46;
    localparam int DIST_W = 46;

    typedef logic signed [PT_W-1:0]   t_coord;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic signed [DIST_W-1:0] t_dist;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_ORIGIN_Z     = 3'd2,
        CFG_SPACING_X    = 3'd3,
        CFG_SPACING_Y    = 3'd4,
        CFG_SPACING_Z    = 3'd5,
        CFG_SPHERE_COUNT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] rad;
        logic               flag;
    } t_sphere;

endpackage

`default_nettype wire

// ===== hw/rtl/ssdf_in_if.sv =====
// ----------------------------------------------------------------------------
// ssdf_in_if
// input word channel: load or evaluate command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssdf_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [3:0]         entry_index;
    logic signed [31:0] ctr_x;
    logic signed [31:0] ctr_y;
    logic signed [31:0] ctr_z;
    logic signed [31:0] sphere_radius;
    logic               inside_positive;
    logic [9:0]         grid_i;
    logic [9:0]         grid_j;
    logic [9:0]         grid_k;

    modport source (output valid, opcode, entry_index, ctr_x, ctr_y, ctr_z,
                    sphere_radius, inside_positive, grid_i, grid_j, grid_k,
                    input ready);
    modport sink (input valid, opcode, entry_index, ctr_x, ctr_y, ctr_z,
                  sphere_radius, inside_positive, grid_i, grid_j, grid_k,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssdf_out_if.sv =====
// ----------------------------------------------------------------------------
// ssdf_out_if
// result word channel: level value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssdf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] level_value;

    modport source (output valid, level_value, input ready);
    modport sink (input valid, level_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssdf_eval.sv =====
// ----------------------------------------------------------------------------
// ssdf_eval
// per sphere distance pipeline: differences, squares, bit pair square root,
// radius subtract and orientation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssdf_eval
    import ssdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  wire t_point  i_pt,
    input  wire t_sphere i_sph,
    output logic         o_vld,
    output t_dist        o_dist,
    output logic         o_busy
);

    function automatic t_mag absdiff(input t_coord p, input logic signed [31:0] c);
        logic signed [PT_W:0] d;
        d = {p[PT_W-1], p} - {{(PT_W-31){c[31]}}, c};
        return d[PT_W] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

    // stage 1: absolute differences
    logic                    r1_vld;
    logic [2:0][MAG_W-1:0]   r1_d;
    logic signed [31:0]      r1_rad;
    logic                    r1_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_d[0] <= absdiff(i_pt.x, i_sph.cx);
        r1_d[1] <= absdiff(i_pt.y, i_sph.cy);
        r1_d[2] <= absdiff(i_pt.z, i_sph.cz);
        r1_rad  <= i_sph.rad;
        r1_flag <= i_sph.flag;
    end

    // stage 2: partial products
    logic                r2_vld;
    logic [2:0][21:0]    r2_hh;
    logic [2:0][42:0]    r2_hl;
    logic [2:0][63:0]    r2_ll;
    logic signed [31:0]  r2_rad;
    logic                r2_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int a = 0; a < 3; a++) begin
            r2_hh[a] <= 22'(r1_d[a][42:32]) * 22'(r1_d[a][42:32]);
            r2_hl[a] <= 43'(r1_d[a][42:32]) * 43'(r1_d[a][31:0]);
            r2_ll[a] <= 64'(r1_d[a][31:0]) * 64'(r1_d[a][31:0]);
        end
        r2_rad  <= r1_rad;
        r2_flag <= r1_flag;
    end

    // stage 3: squares per axis
    logic                 r3_vld;
    logic [2:0][SQ_W-1:0] r3_sq;
    logic signed [31:0]   r3_rad;
    logic                 r3_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        for (int a = 0; a < 3; a++) begin
            r3_sq[a] <= SQ_W'({r2_hh[a], 64'b0}) + (SQ_W'(r2_hl[a]) << 33)
                        + SQ_W'(r2_ll[a]);
        end
        r3_rad  <= r2_rad;
        r3_flag <= r2_flag;
    end

    // stage 4: sum of squares
    logic                r4_vld;
    logic [SQ_W-1:0]     r4_sum;
    logic signed [31:0]  r4_rad;
    logic                r4_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_sum  <= r3_sq[0] + r3_sq[1] + r3_sq[2];
        r4_rad  <= r3_rad;
        r4_flag <= r3_flag;
    end

    // square root, one result bit per stage
    logic [ROOT_W-1:0]                 r_rt_vld;
    logic [ROOT_W-1:0][REM_W-1:0]      r_rt_rem;
    logic [ROOT_W-1:0][ROOT_W-1:0]     r_rt_root;
    logic [ROOT_W-1:0][SQ_W-1:0]       r_rt_sum;
    logic [ROOT_W-1:0][31:0]           r_rt_rad;
    logic [ROOT_W-1:0]                 r_rt_flag;
    wire  [ROOT_W-1:0][REM_W-1:0]      n_rt_rem;
    wire  [ROOT_W-1:0][ROOT_W-1:0]     n_rt_root;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_root
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [1:0]        w_pair;
        logic [REM_W+1:0]  w_sh;
        logic [REM_W+1:0]  w_trial;
        logic              w_take;

        if (s == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_pair = r4_sum[SQ_W-1 -: 2];
        end else begin : g_next
            assign w_rem  = r_rt_rem[s-1];
            assign w_root = r_rt_root[s-1];
            assign w_pair = r_rt_sum[s-1][SQ_W-1 -: 2];
        end

        assign w_sh         = {w_rem, w_pair};
        assign w_trial      = {2'b00, w_root, 2'b01};
        assign w_take       = (w_sh >= w_trial);
        assign n_rt_rem[s]  = w_take ? REM_W'(w_sh - w_trial) : REM_W'(w_sh);
        assign n_rt_root[s] = {w_root[ROOT_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld <= '0;
        end else begin
            r_rt_vld <= {r_rt_vld[ROOT_W-2:0], r4_vld};
        end
        r_rt_rem     <= n_rt_rem;
        r_rt_root    <= n_rt_root;
        r_rt_sum[0]  <= {r4_sum[SQ_W-3:0], 2'b00};
        r_rt_rad[0]  <= r4_rad;
        r_rt_flag[0] <= r4_flag;
        for (int s = 1; s < ROOT_W; s++) begin
            r_rt_sum[s]  <= {r_rt_sum[s-1][SQ_W-3:0], 2'b00};
            r_rt_rad[s]  <= r_rt_rad[s-1];
            r_rt_flag[s] <= r_rt_flag[s-1];
        end
    end

    // last stage: subtract radius, apply orientation
    logic  r_o_vld;
    t_dist r_o_dist;
    t_dist w_v;

    assign w_v = $signed({2'b00, r_rt_root[ROOT_W-1]})
                 - $signed({{(DIST_W-32){r_rt_rad[ROOT_W-1][31]}}, r_rt_rad[ROOT_W-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_rt_vld[ROOT_W-1];
        end
        r_o_dist <= r_rt_flag[ROOT_W-1] ? -w_v : w_v;
    end

    assign o_vld  = r_o_vld;
    assign o_dist = r_o_dist;
    assign o_busy = r1_vld | r2_vld | r3_vld | r4_vld | (|r_rt_vld) | r_o_vld;

endmodule

`default_nettype wire

// ===== hw/rtl/sphere_signed_distance_field.sv =====
// ----------------------------------------------------------------------------
// sphere_signed_distance_field
// signed distance to a table of spheres, combined by maximum, Q16.16
//
//   channel  dir  words
//   i_in     in   load (table slot) or evaluate (grid point)
//   o_out    out  level value, one per evaluate
//   cfg      in   origin, spacing, sphere count writes
//
// a load writes its table slot and leaves the block ready. an evaluate computes
// its point from the grid indices, issues the spheres into the pipeline in turn,
// folds each distance into the running maximum, waits for the pipeline to empty
// and saturates the maximum into the output register; the block is ready for
// the next word in the cycle after the result is loaded. synchronous active low
// reset clears control; the table is undefined until loaded. a stalled result
// sits in the output register while the next word is taken; a further evaluate
// then waits in its last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sphere_signed_distance_field
    import ssdf_pkg::*;
#(
    parameter int MAX_SPHERES  = 16,
    parameter int GRID_DIM_MAX = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    ssdf_in_if.sink          i_in,
    ssdf_out_if.source       o_out
);

    localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW = $clog2(MAX_SPHERES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_ISSUE,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // configuration
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic [30:0]        r_sp_x, r_sp_y, r_sp_z;
    logic [4:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_sp_x  <= 31'd65536;
            r_sp_y  <= 31'd65536;
            r_sp_z  <= 31'd65536;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:     r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y:     r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z:     r_org_z <= i_cfg_data;
                CFG_SPACING_X:    r_sp_x  <= i_cfg_data[30:0];
                CFG_SPACING_Y:    r_sp_y  <= i_cfg_data[30:0];
                CFG_SPACING_Z:    r_sp_z  <= i_cfg_data[30:0];
                CFG_SPHERE_COUNT: r_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    function automatic logic [9:0] clamp_idx(input logic [9:0] idx);
        return ({22'b0, idx} >= GRID_DIM_MAX) ? 10'(GRID_DIM_MAX - 1) : idx;
    endfunction

    function automatic t_coord coord(input logic signed [31:0] org,
                                     input logic [30:0] sp, input logic [9:0] idx);
        logic [40:0] p;
        p = 41'(sp) * 41'(idx);
        return {{(PT_W-32){org[31]}}, org} + {2'b00, p};
    endfunction

    // handshake
    t_state  r_state;
    logic    w_in_acc;
    logic    w_out_acc;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid & i_in.ready;
    assign w_out_acc  = o_out.valid & o_out.ready;

    // sphere table
    t_sphere         mem_sph [MAX_SPHERES];
    t_sphere         r_sph;
    logic [CW-1:0]   r_n;
    logic [CW-1:0]   w_cnt;

    assign w_cnt = ({27'b0, r_count} > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(r_count);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (t_opcode'(i_in.opcode) == OP_LOAD)
            && ({28'b0, i_in.entry_index} < MAX_SPHERES)) begin
            mem_sph[IW'(i_in.entry_index)] <= '{cx: i_in.ctr_x, cy: i_in.ctr_y,
                                               cz: i_in.ctr_z, rad: i_in.sphere_radius,
                                               flag: i_in.inside_positive};
        end
        r_sph <= mem_sph[r_n[IW-1:0]];
    end

    // distance pipeline
    logic    w_ev_vld;
    t_dist   w_ev_dist;
    logic    w_ev_busy;
    logic    r_sph_vld;
    t_point  r_pt;

    ssdf_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_sph_vld),
        .i_pt    (r_pt),
        .i_sph   (r_sph),
        .o_vld   (w_ev_vld),
        .o_dist  (w_ev_dist),
        .o_busy  (w_ev_busy)
    );

    // sequencer, accumulator and output register
    logic [9:0]         r_gi, r_gj, r_gk;
    t_dist              r_best;
    logic               r_out_vld;
    logic signed [31:0] r_out_val;
    logic               w_fin_load;

    assign w_fin_load = (r_state == ST_FIN) && (!r_out_vld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sph_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_n       <= '0;
        end else begin
            if (w_out_acc && !w_fin_load) begin
                r_out_vld <= 1'b0;
            end
            r_sph_vld <= 1'b0;
            if (r_state == ST_COORD) begin
                r_best <= {1'b1, {(DIST_W-1){1'b0}}};
            end else if (w_ev_vld && (w_ev_dist > r_best)) begin
                r_best <= w_ev_dist;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (t_opcode'(i_in.opcode) == OP_EVAL)) begin
                        r_gi    <= clamp_idx(i_in.grid_i);
                        r_gj    <= clamp_idx(i_in.grid_j);
                        r_gk    <= clamp_idx(i_in.grid_k);
                        r_state <= ST_COORD;
                    end
                end
                ST_COORD: begin
                    r_pt.x  <= coord(r_org_x, r_sp_x, r_gi);
                    r_pt.y  <= coord(r_org_y, r_sp_y, r_gj);
                    r_pt.z  <= coord(r_org_z, r_sp_z, r_gk);
                    r_n     <= '0;
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (r_n < w_cnt) begin
                        r_sph_vld <= 1'b1;
                        r_n       <= r_n + 1'b1;
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_sph_vld && !w_ev_busy) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fin_load) begin
                        r_out_vld <= 1'b1;
                        if (r_best > t_dist'(32'sh7fffffff)) begin
                            r_out_val <= 32'sh7fffffff;
                        end else if (r_best < -t_dist'(33'sh080000000)) begin
                            r_out_val <= 32'sh80000000;
                        end else begin
                            r_out_val <= r_best[31:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.level_value = r_out_val;

    `SSDF_ASSERT(a_ready_idle_pipe, i_clk, i_rst_n, i_in.ready |-> !(w_ev_busy || r_sph_vld), "busy at ready")
    `SSDF_ASSERT(a_result_in_eval, i_clk, i_rst_n, w_ev_vld |-> (r_state == ST_ISSUE || r_state == ST_DRAIN), "stray result")
    `SSDF_ASSERT(a_fin_loads_out, i_clk, i_rst_n, w_fin_load |=> (r_out_vld && r_state == ST_IDLE), "final value not loaded")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sphere_signed_distance_field: loads the sphere
// table, walks through several origin / spacing / count settings and compares
// every level value with an exact bit-true prediction kept in a scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ssdf_pkg::*;

    typedef struct {
        t_opcode            op;
        logic [3:0]         slot;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] rad;
        logic               flag;
        logic [9:0]         gi;
        logic [9:0]         gj;
        logic [9:0]         gk;
    } t_cmd_word;

    class level_scoreboard;
        logic signed [31:0] org [3];
        logic [30:0]        spc [3];
        logic [4:0]         count;
        logic signed [31:0] tcx [16];
        logic signed [31:0] tcy [16];
        logic signed [31:0] tcz [16];
        logic signed [31:0] trad [16];
        logic               tflag [16];
        logic [31:0]        level_q [$];
        int                 mismatches;

        function new();
            for (int a = 0; a < 3; a++) begin
                org[a] = 0;
                spc[a] = 31'd65536;
            end
            count = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_ORIGIN_X:     org[0] = data;
                CFG_ORIGIN_Y:     org[1] = data;
                CFG_ORIGIN_Z:     org[2] = data;
                CFG_SPACING_X:    spc[0] = data[30:0];
                CFG_SPACING_Y:    spc[1] = data[30:0];
                CFG_SPACING_Z:    spc[2] = data[30:0];
                CFG_SPHERE_COUNT: count = data[4:0];
                default: ;
            endcase
        endfunction

        function longint grid_coord(int a, logic [9:0] idx);
            return longint'(org[a]) + longint'({33'd0, spc[a]}) * longint'({54'd0, idx});
        endfunction

        function logic [127:0] sq_diff(longint p, longint c);
            longint d;
            logic [127:0] m;
            d = p - c;
            if (d < 0) d = -d;
            m = {64'd0, d};
            return m * m;
        endfunction

        function longint floor_root(logic [127:0] s);
            logic [127:0] r, c;
            r = 0;
            for (int b = 46; b >= 0; b--) begin
                c = r | (128'd1 << b);
                if (c * c <= s) r = c;
            end
            return longint'(r[63:0]);
        endfunction

        function logic [31:0] level_of(t_cmd_word w);
            longint px, py, pz, v, best;
            logic [127:0] s;
            int n;
            px = grid_coord(0, w.gi);
            py = grid_coord(1, w.gj);
            pz = grid_coord(2, w.gk);
            n = (count > 16) ? 16 : count;
            best = 64'sh8000000000000000;
            for (int e = 0; e < n; e++) begin
                s = sq_diff(px, tcx[e]) + sq_diff(py, tcy[e]) + sq_diff(pz, tcz[e]);
                v = floor_root(s) - longint'(trad[e]);
                if (tflag[e]) v = -v;
                if (v > best) best = v;
            end
            if (best > 64'sd2147483647) best = 64'sd2147483647;
            if (best < -64'sd2147483648) best = -64'sd2147483648;
            return best[31:0];
        endfunction

        function void note_word(t_cmd_word w);
            if (w.op == OP_LOAD) begin
                tcx[w.slot] = w.cx;
                tcy[w.slot] = w.cy;
                tcz[w.slot] = w.cz;
                trad[w.slot] = w.rad;
                tflag[w.slot] = w.flag;
            end else begin
                level_q.push_back(level_of(w));
            end
        endfunction

        function void check_level(logic [31:0] got);
            logic [31:0] want;
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected level word %h", got);
                return;
            end
            want = level_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("level_value mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    bit          quiet;
    bit          hold_req;
    level_scoreboard sb;

    ssdf_in_if  cmd_bus ();
    ssdf_out_if lvl_bus ();

    sphere_signed_distance_field uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_bus),
        .o_out      (lvl_bus)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n && lvl_bus.valid && lvl_bus.ready)
            sb.check_level(lvl_bus.level_value);
        if (hold_req) begin
            hold_req = 0;
            lvl_bus.ready <= 1'b0;
            repeat (400) @(posedge i_clk);
            lvl_bus.ready <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            lvl_bus.ready <= 1'b0;
            repeat (gap) @(posedge i_clk);
            lvl_bus.ready <= 1'b1;
        end else begin
            lvl_bus.ready <= 1'b1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_grid(logic [31:0] o0, logic [31:0] o1, logic [31:0] o2,
                            logic [30:0] s0, logic [30:0] s1, logic [30:0] s2,
                            logic [4:0] n);
        write_reg(CFG_ORIGIN_X, o0);
        write_reg(CFG_ORIGIN_Y, o1);
        write_reg(CFG_ORIGIN_Z, o2);
        write_reg(CFG_SPACING_X, {1'b0, s0});
        write_reg(CFG_SPACING_Y, {1'b0, s1});
        write_reg(CFG_SPACING_Z, {1'b0, s2});
        write_reg(CFG_SPHERE_COUNT, {27'd0, n});
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(t_cmd_word w);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.opcode          <= w.op;
        cmd_bus.entry_index     <= w.slot;
        cmd_bus.ctr_x           <= w.cx;
        cmd_bus.ctr_y           <= w.cy;
        cmd_bus.ctr_z           <= w.cz;
        cmd_bus.sphere_radius   <= w.rad;
        cmd_bus.inside_positive <= w.flag;
        cmd_bus.grid_i          <= w.gi;
        cmd_bus.grid_j          <= w.gj;
        cmd_bus.grid_k          <= w.gk;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (sb.level_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q(int wide);
        if (wide != 0) return $urandom();
        return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endfunction

    function automatic t_cmd_word load_word(logic [3:0] slot, logic [31:0] cx,
                                            logic [31:0] cy, logic [31:0] cz,
                                            logic [31:0] rad, logic flag);
        t_cmd_word w;
        w.op = OP_LOAD;
        w.slot = slot;
        w.cx = cx;
        w.cy = cy;
        w.cz = cz;
        w.rad = rad;
        w.flag = flag;
        w.gi = 10'($urandom());
        w.gj = 10'($urandom());
        w.gk = 10'($urandom());
        return w;
    endfunction

    function automatic t_cmd_word eval_word(logic [9:0] gi, logic [9:0] gj, logic [9:0] gk);
        t_cmd_word w;
        w.op = OP_EVAL;
        w.slot = 4'($urandom());
        w.cx = $urandom();
        w.cy = $urandom();
        w.cz = $urandom();
        w.rad = $urandom();
        w.flag = 1'($urandom());
        w.gi = gi;
        w.gj = gj;
        w.gk = gk;
        return w;
    endfunction

    function automatic t_cmd_word rand_word();
        int wide;
        wide = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
            return load_word(4'($urandom()), rand_q(wide), rand_q(wide), rand_q(wide),
                             rand_q(wide), 1'($urandom()));
        if ($urandom_range(0, 3) == 0)
            return eval_word(10'($urandom()), 10'($urandom()), 10'($urandom()));
        return eval_word(10'($urandom_range(0, 63)), 10'($urandom_range(0, 63)),
                         10'($urandom_range(0, 63)));
    endfunction

    task automatic random_run(int n);
        for (int a = 0; a < n; a++) send_word(rand_word());
    endtask

    initial begin
        sb = new();
        quiet = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ORIGIN_X;
        cfg_data = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.opcode = OP_LOAD;
        cmd_bus.entry_index = '0;
        cmd_bus.ctr_x = '0;
        cmd_bus.ctr_y = '0;
        cmd_bus.ctr_z = '0;
        cmd_bus.sphere_radius = '0;
        cmd_bus.inside_positive = 1'b0;
        cmd_bus.grid_i = '0;
        cmd_bus.grid_j = '0;
        cmd_bus.grid_k = '0;
        lvl_bus.ready = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no spheres at reset
        send_word(eval_word(10'd0, 10'd0, 10'd0));
        send_word(eval_word(10'd1023, 10'd1023, 10'd1023));
        // fill the whole table, extremes first
        send_word(load_word(4'd0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0));
        send_word(load_word(4'd15, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h7fff_ffff, 1'b1));
        send_word(load_word(4'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 1'b0));
        send_word(load_word(4'd2, 32'h0003_0000, 32'h0, 32'h0, 32'h8000_0000, 1'b1));
        for (int e = 3; e < 15; e++)
            send_word(load_word(4'(e), rand_q(0), rand_q(0), rand_q(0), rand_q(0),
                                1'($urandom())));
        drain();

        // single sphere, then all, then count beyond the table
        set_grid(32'h0, 32'h0, 32'h0, 31'd65536, 31'd65536, 31'd65536, 5'd1);
        send_word(eval_word(10'd3, 10'd4, 10'd0));
        send_word(eval_word(10'd0, 10'd0, 10'd0));
        drain();
        set_grid(32'h0, 32'h0, 32'h0, 31'd65536, 31'd65536, 31'd65536, 5'd16);
        send_word(eval_word(10'd1023, 10'd0, 10'd512));
        send_word(eval_word(10'd5, 10'd5, 10'd5));
        drain();
        set_grid(32'h0, 32'h0, 32'h0, 31'd65536, 31'd65536, 31'd65536, 5'd31);
        send_word(eval_word(10'd7, 10'd1023, 10'd0));
        drain();

        set_grid(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 5'd16);
        hold_req = 1;
        random_run(200);
        drain();

        set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 31'd0, 5'd31);
        random_run(200);
        drain();

        set_grid(rand_q(0), rand_q(0), rand_q(0), 31'($urandom_range(0, 32'h0004_0000)),
                 31'($urandom_range(0, 32'h0004_0000)),
                 31'($urandom_range(0, 32'h0004_0000)), 5'd1);
        random_run(200);
        drain();

        set_grid($urandom(), $urandom(), $urandom(), 31'($urandom()), 31'($urandom()),
                 31'($urandom()), 5'($urandom_range(2, 15)));
        random_run(200);
        drain();

        quiet = 1;
        set_grid(rand_q(0), rand_q(0), rand_q(0), 31'($urandom_range(0, 32'h0002_0000)),
                 31'($urandom_range(0, 32'h0002_0000)),
                 31'($urandom_range(0, 32'h0002_0000)),
                 5'($urandom_range(0, 31)));
        random_run(280);
        drain();

        if (sb.mismatches == 0 && sb.level_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
